FILE: rtl/core/hsvrgb_pkg.sv
// Shared constants for the HSV to RGB565 converter: hue scale, sector width,
// datapath widths and the reciprocal used for the final constant division.
// Depends on nothing.
package hsvrgb_pkg;

    localparam int unsigned HUE_STEPS_PER_DEGREE = 64;

    localparam int unsigned HUE_W       = 15;
    localparam int unsigned SAT_W       = 8;
    localparam int unsigned VAL_W       = 8;
    localparam int unsigned RGB_W       = 16;
    localparam int unsigned CHAN_W      = 6;
    localparam int unsigned SCALE_W     = 6;
    localparam int unsigned RED_MAX     = 31;
    localparam int unsigned GREEN_MAX   = 63;
    localparam int unsigned BLUE_MAX    = 31;
    localparam int unsigned RED_W       = 5;
    localparam int unsigned GREEN_W     = 6;
    localparam int unsigned BLUE_W      = 5;
    localparam int unsigned NUM_SECTORS = 6;

    localparam int unsigned SECTOR_W    = 60 * HUE_STEPS_PER_DEGREE;
    localparam int unsigned FULL_CIRCLE = 360 * HUE_STEPS_PER_DEGREE;
    localparam int unsigned FRAC_W      = $clog2(SECTOR_W);
    localparam int unsigned G_W         = $clog2(SECTOR_W + 1);

    localparam int unsigned X_MAX       = 255 * SECTOR_W;
    localparam int unsigned X_W         = $clog2(X_MAX + 1);
    localparam int unsigned P_W         = X_W + VAL_W;
    localparam int unsigned M_W         = P_W + SCALE_W;

    localparam longint unsigned DEN     = 64'd65025 * 64'(SECTOR_W);
    localparam longint unsigned RECIP   = (64'd1 << M_W) / DEN;
    localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
    localparam int unsigned PROD_W      = M_W + RECIP_W;

    localparam int unsigned NSTAGE      = 6;

endpackage

FILE: rtl/core/hsvrgb_chan.sv
// One colour channel of the converter: forms v*(255W - s*g), scales it to the
// channel range and divides by the common denominator through a reciprocal.
// Depends on hsvrgb_pkg.
module hsvrgb_chan import hsvrgb_pkg::*; (
    input  logic                aclk,
    input  logic [NSTAGE-2:0]   en,
    input  logic [SCALE_W-1:0]  full_scale,
    input  logic [G_W-1:0]      g_in,
    input  logic [SAT_W-1:0]    sat_in,
    input  logic [VAL_W-1:0]    val_in,
    output logic [CHAN_W-1:0]   chan_out
);

    logic [X_W-1:0]     x_reg, x_next;
    logic [VAL_W-1:0]   v2_reg;
    logic [P_W-1:0]     p_reg, p_next;
    logic [M_W-1:0]     m_reg, m_next;
    logic [M_W-1:0]     m5_reg;
    logic [CHAN_W-1:0]  q0_reg, q0_next;
    logic [CHAN_W-1:0]  q_reg, q_next;
    logic [PROD_W-1:0]  recip_prod;
    logic [M_W-1:0]     rem;

    always_comb begin
        x_next     = X_W'(X_MAX) - X_W'(X_W'(sat_in) * X_W'(g_in));
        p_next     = P_W'(v2_reg) * P_W'(x_reg);
        m_next     = M_W'(p_reg) * M_W'(full_scale);
        recip_prod = PROD_W'(m_reg) * PROD_W'(RECIP);
        q0_next    = CHAN_W'(recip_prod >> M_W);
        rem        = m5_reg - M_W'(M_W'(q0_reg) * M_W'(DEN));
        q_next     = (rem >= M_W'(DEN)) ? q0_reg + CHAN_W'(1) : q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg  <= x_next;
            v2_reg <= val_in;
        end
        if (en[1]) begin
            p_reg <= p_next;
        end
        if (en[2]) begin
            m_reg <= m_next;
        end
        if (en[3]) begin
            q0_reg <= q0_next;
            m5_reg <= m_reg;
        end
        if (en[4]) begin
            q_reg <= q_next;
        end
    end

    assign chan_out = q_reg;

endmodule

FILE: rtl/core/hsv_to_rgb565_converter.sv
// Top level of the HSV to RGB565 converter: input stage (hue wrap, sector and
// fraction) and valid/ready pipeline control. Depends on hsvrgb_pkg, hsvrgb_chan.
//
// The block converts one HSV colour per item into one packed RGB565 word.
// The input channel (s_valid, s_ready, s_hue, s_saturation, s_brightness)
// takes hue in 1/64 degree, saturation and brightness on 0..255; a hue of a
// full circle or more counts as zero. The result channel (m_valid, m_ready,
// m_rgb565) gives red in bits 15..11, green in 10..5 and blue in 4..0.
// The datapath is a six-stage pipeline: sector decode, saturation product,
// brightness product, channel scaling, reciprocal multiply and remainder
// correction. One item is taken in every cycle while the receiver takes
// results; each stage has its own valid bit and advances when it is empty
// or the next stage advances, so empty slots close up while the receiver
// stalls. When m_ready is low with the pipeline full, s_ready falls;
// nothing is lost or repeated. Reset clears all valid bits and holds
// s_ready low; the block is ready in the first cycle after reset is
// released.
module hsv_to_rgb565_converter import hsvrgb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [HUE_W-1:0]  s_hue,
    input  logic [SAT_W-1:0]  s_saturation,
    input  logic [VAL_W-1:0]  s_brightness,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RGB_W-1:0]  m_rgb565
);

    typedef enum logic [1:0] {
        G_ZERO,
        G_WIDTH,
        G_FRAC,
        G_COMP
    } g_sel_t;

    typedef enum logic [2:0] {
        SEC_0, SEC_1, SEC_2, SEC_3, SEC_4, SEC_5
    } sector_t;

    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE-1:0] en;

    logic [HUE_W-1:0]  hue_w;
    logic [HUE_W-1:0]  base;
    logic [FRAC_W-1:0] frac;
    sector_t           sector;
    g_sel_t            sel_r, sel_g, sel_b;

    logic [G_W-1:0]    gr_reg, gg_reg, gb_reg;
    logic [G_W-1:0]    gr_next, gg_next, gb_next;
    logic [SAT_W-1:0]  sat_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CHAN_W-1:0] red, green, blue;

    function automatic logic [G_W-1:0] g_value(g_sel_t sel, logic [FRAC_W-1:0] f);
        logic [G_W-1:0] res;
        case (sel)
            G_ZERO:  res = '0;
            G_WIDTH: res = G_W'(SECTOR_W);
            G_FRAC:  res = G_W'(f);
            default: res = G_W'(SECTOR_W) - G_W'(f);
        endcase
        return res;
    endfunction

    always_comb begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = s_valid;
        for (int i = 1; i < NSTAGE; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_comb begin
        hue_w  = (32'(s_hue) >= 32'(FULL_CIRCLE)) ? '0 : s_hue;
        sector = SEC_0;
        base   = '0;
        for (int i = 1; i < NUM_SECTORS; i++) begin
            if (32'(hue_w) >= 32'(i) * 32'(SECTOR_W)) begin
                sector = sector_t'(i);
                base   = HUE_W'(32'(i) * 32'(SECTOR_W));
            end
        end
        frac = FRAC_W'(hue_w - base);

        unique case (sector)
            SEC_0: begin
                sel_r = G_ZERO;  sel_g = G_COMP;  sel_b = G_WIDTH;
            end
            SEC_1: begin
                sel_r = G_FRAC;  sel_g = G_ZERO;  sel_b = G_WIDTH;
            end
            SEC_2: begin
                sel_r = G_WIDTH; sel_g = G_ZERO;  sel_b = G_COMP;
            end
            SEC_3: begin
                sel_r = G_WIDTH; sel_g = G_FRAC;  sel_b = G_ZERO;
            end
            SEC_4: begin
                sel_r = G_COMP;  sel_g = G_WIDTH; sel_b = G_ZERO;
            end
            default: begin
                sel_r = G_ZERO;  sel_g = G_WIDTH; sel_b = G_FRAC;
            end
        endcase

        gr_next = g_value(sel_r, frac);
        gg_next = g_value(sel_g, frac);
        gb_next = g_value(sel_b, frac);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            gr_reg  <= gr_next;
            gg_reg  <= gg_next;
            gb_reg  <= gb_next;
            sat_reg <= s_saturation;
            val_reg <= s_brightness;
        end
    end

    hsvrgb_chan u_chan_red (
        .aclk       (aclk),
        .en         (en[NSTAGE-1:1]),
        .full_scale (SCALE_W'(RED_MAX)),
        .g_in       (gr_reg),
        .sat_in     (sat_reg),
        .val_in     (val_reg),
        .chan_out   (red)
    );

    hsvrgb_chan u_chan_green (
        .aclk       (aclk),
        .en         (en[NSTAGE-1:1]),
        .full_scale (SCALE_W'(GREEN_MAX)),
        .g_in       (gg_reg),
        .sat_in     (sat_reg),
        .val_in     (val_reg),
        .chan_out   (green)
    );

    hsvrgb_chan u_chan_blue (
        .aclk       (aclk),
        .en         (en[NSTAGE-1:1]),
        .full_scale (SCALE_W'(BLUE_MAX)),
        .g_in       (gb_reg),
        .sat_in     (sat_reg),
        .val_in     (val_reg),
        .chan_out   (blue)
    );

    assign s_ready  = en[0] && aresetn;
    assign m_valid  = vld_reg[NSTAGE-1];
    assign m_rgb565 = {red[RED_W-1:0], green[GREEN_W-1:0], blue[BLUE_W-1:0]};

endmodule

FILE: rtl/core/hsvrgb_checker.sv
// Port-level checker for the HSV to RGB565 converter, with the bind that
// attaches it to the top level. Depends on hsvrgb_pkg.
module hsvrgb_checker import hsvrgb_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [RGB_W-1:0]  m_rgb565
);

    // A stalled result keeps its valid and its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rgb565))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // When the output moves or is empty, the whole pipeline moves, so the
    // input side must be ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready || !m_valid |-> s_ready)
        else $error("input stalled while output is free");

endmodule

bind hsv_to_rgb565_converter hsvrgb_checker u_hsvrgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_rgb565 (m_rgb565)
);
